// ----- rtl/sha_pkg.sv -----
// sha-256 constants, round functions and state codes
package sha_pkg;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_COMP = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  // input commands
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadMark    = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t InitWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // rotate right by a constant amount
  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// sha-256 byte stream hasher top level
//
// Input channel (in_valid_i/in_ready_o): each request carries cmd_i and data_byte_i.
// An absorb request (cmd 0) adds one message byte. When it fills the 64-byte block,
// input stalls while the block is compressed: message memory prefetch, 64 rounds
// at one round per cycle, then the chaining memory add.
// A finish request (cmd 1) writes the padding one byte per cycle (64 minus the bytes
// held), compresses, and when 56 or more bytes were held pads and compresses a
// second block. The eight digest words then leave on the output channel
// (out_valid_o/out_ready_i), word 0 first, one per cycle while the receiver takes
// them; a stalled receiver holds the current word and the sequencer waits.
// A new request is taken once the eighth word sits in the output register.
// Absorb throughput is set by the single round unit; input waits during compression.
// Reset (rst_ni low) returns the chaining state to the initial hash values and
// empties the block buffer and output register; no clearing pass is needed.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam int unsigned PosW   = $clog2(BlockBytes);
  localparam int unsigned WAddrW = PosW - 2;

  state_e           state_q, state_d;
  logic [PosW-1:0]  fill_q, fill_d;
  logic [63:0]      bits_q, bits_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             fin_q, fin_d;
  logic             mark_q, mark_d;
  logic             two_q, two_d;
  logic             lastblk_q, lastblk_d;
  logic [5:0]       rnd_q, rnd_d;
  logic [3:0]       add_q, add_d;
  logic [2:0]       ocnt_q, ocnt_d;
  logic [7:0]       cvalid_q, cvalid_d;
  logic             out_valid_q, out_valid_d;
  word_t            v_q [8];
  word_t            v_d [8];
  word_t            wwin_q [16];
  word_t            wwin_d [16];
  word_t            out_word_q, out_word_d;
  logic [2:0]       out_idx_q, out_idx_d;

  // message block memory, big-endian words with byte lanes
  word_t              msg_mem [BlockBytes/4];
  word_t              mrd_q;
  logic               mwe;
  logic [PosW-1:0]    mwpos;
  logic [7:0]         mbyte;
  logic [WAddrW-1:0]  mraddr;
  logic [4:0]         mlane_sh;

  // chaining word memory
  word_t       chain_mem [8];
  word_t       crd_q;
  logic        cvrd_q;
  logic        cwe;
  logic [2:0]  cwaddr;
  word_t       csum;
  word_t       chain_old;

  logic        in_acc;
  word_t       w_t, w_new;
  word_t       t1, t2;
  logic [63:0] len_sh;
  logic [7:0]  len_byte;

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // message schedule word for the current round
  assign w_new = ssig1(wwin_q[14]) + wwin_q[9] + ssig0(wwin_q[1]) + wwin_q[0];
  assign w_t   = (rnd_q[5:4] == 2'b00) ? mrd_q : w_new;

  // round function
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_t;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // length byte for the tail of the last block
  assign len_sh   = bits_q >> {~pos_q[2:0], 3'b000};
  assign len_byte = len_sh[7:0];

  // chaining add: invalid entries read as the initial values
  assign cwaddr    = 3'(add_q - 4'd1);
  assign chain_old = cvrd_q ? crd_q : InitWords[cwaddr];
  assign csum      = chain_old + v_q[0];

  assign mraddr   = (state_q == ST_COMP) ? WAddrW'(rnd_q[WAddrW-1:0] + 1'b1) : '0;
  assign mlane_sh = {~mwpos[1:0], 3'b000};

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bits_d      = bits_q;
    pos_d       = pos_q;
    fin_d       = fin_q;
    mark_d      = mark_q;
    two_d       = two_q;
    lastblk_d   = lastblk_q;
    rnd_d       = rnd_q;
    add_d       = add_q;
    ocnt_d      = ocnt_q;
    cvalid_d    = cvalid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    v_d         = v_q;
    wwin_d      = wwin_q;
    mwe         = 1'b0;
    mwpos       = fill_q;
    mbyte       = data_byte_i;
    cwe         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_ABSORB) begin
            mwe    = 1'b1;
            fill_d = fill_q + 1'b1;
            bits_d = bits_q + 64'd8;
            if (&fill_q) begin
              state_d = ST_PREP;
            end
          end else begin
            fin_d   = 1'b1;
            mark_d  = 1'b1;
            two_d   = (fill_q >= PosW'(LenPos));
            pos_d   = fill_q;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // marker byte, then zeros, then the length in the last block
        mwe    = 1'b1;
        mwpos  = pos_q;
        if (mark_q) begin
          mbyte = PadMark;
        end else if ((pos_q >= PosW'(LenPos)) && !two_q) begin
          mbyte = len_byte;
        end else begin
          mbyte = 8'h00;
        end
        mark_d = 1'b0;
        pos_d  = pos_q + 1'b1;
        if (&pos_q) begin
          lastblk_d = !two_q;
          two_d     = 1'b0;
          state_d   = ST_PREP;
        end
      end
      ST_PREP: begin
        rnd_d   = '0;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        v_d[0] = t1 + t2;
        v_d[1] = v_q[0];
        v_d[2] = v_q[1];
        v_d[3] = v_q[2];
        v_d[4] = v_q[3] + t1;
        v_d[5] = v_q[4];
        v_d[6] = v_q[5];
        v_d[7] = v_q[6];
        for (int i = 0; i < 15; i++) begin
          wwin_d[i] = wwin_q[i+1];
        end
        wwin_d[15] = w_t;
        rnd_d      = rnd_q + 1'b1;
        if (&rnd_q) begin
          add_d   = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        add_d = add_q + 1'b1;
        if (add_q != 4'd0) begin
          cwe              = 1'b1;
          cvalid_d[cwaddr] = 1'b1;
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
          v_d[7] = csum;
        end
        if (add_q == 4'd8) begin
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (!lastblk_q) begin
            pos_d   = '0;
            state_d = ST_PAD;
          end else begin
            ocnt_d  = '0;
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d  = v_q[0];
          out_idx_d   = ocnt_q;
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
          v_d[7] = v_q[0];
          ocnt_d = ocnt_q + 1'b1;
          if (&ocnt_q) begin
            // back to the initial values for the next message
            v_d      = InitWords;
            cvalid_d = '0;
            fill_d   = '0;
            bits_d   = '0;
            fin_d    = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bits_q      <= '0;
      pos_q       <= '0;
      fin_q       <= 1'b0;
      mark_q      <= 1'b0;
      two_q       <= 1'b0;
      lastblk_q   <= 1'b0;
      rnd_q       <= '0;
      add_q       <= '0;
      ocnt_q      <= '0;
      cvalid_q    <= '0;
      out_valid_q <= 1'b0;
      v_q         <= InitWords;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bits_q      <= bits_d;
      pos_q       <= pos_d;
      fin_q       <= fin_d;
      mark_q      <= mark_d;
      two_q       <= two_d;
      lastblk_q   <= lastblk_d;
      rnd_q       <= rnd_d;
      add_q       <= add_d;
      ocnt_q      <= ocnt_d;
      cvalid_q    <= cvalid_d;
      out_valid_q <= out_valid_d;
      v_q         <= v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wwin_q     <= wwin_d;
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
  end

  // message memory: byte write, word read
  always_ff @(posedge clk_i) begin
    if (mwe) begin
      msg_mem[mwpos[PosW-1:2]][mlane_sh +: 8] <= mbyte;
    end
    mrd_q <= msg_mem[mraddr];
  end

  // chaining memory: read-add-write, one word per cycle
  always_ff @(posedge clk_i) begin
    if (cwe) begin
      chain_mem[cwaddr] <= csum;
    end
    crd_q  <= chain_mem[add_q[2:0]];
    cvrd_q <= cvalid_q[add_q[2:0]];
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = &out_idx_q;

`ifndef SYNTHESIS
  // a byte that completes the block starts compression
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CMD_ABSORB) && (&fill_q)) |=> (state_q == ST_PREP))
    else $error("full block did not start compression");

  // the last round hands over to the chaining add
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COMP) && (&rnd_q)) |=> (state_q == ST_ADD))
    else $error("compression did not end after 64 rounds");

  // digest words follow in order with no gap while taken
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
      (out_valid_o && (word_index_o == ($past(word_index_o) + 3'd1))))
    else $error("digest word out of order");

  // a finish request blocks input until the digest is out
  a_finish_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CMD_FINISH)) |=> !in_ready_o)
    else $error("input taken during finish");
`endif

endmodule
